/* design/wrrq_pkg.sv */
// ----------------------------------------------------------------------------
// wrrq_pkg
// Shared codes and types of the weighted round-robin run queue.
// ----------------------------------------------------------------------------
`default_nettype none

package wrrq_pkg;

  localparam int ID_BITS      = 5;
  localparam int SLICE_BITS   = 16;
  localparam int Q_BITS       = 8;
  localparam int MAX_TASKS_D  = 32;
  localparam int WEIGHT_BITS_D = 8;
  localparam logic [Q_BITS-1:0] Q_RESET = 8'd10;

  // operation codes of a request
  localparam logic [2:0] FN_ENQ   = 3'd0;
  localparam logic [2:0] FN_DEQ   = 3'd1;
  localparam logic [2:0] FN_TICK  = 3'd2;
  localparam logic [2:0] FN_YIELD = 3'd3;
  localparam logic [2:0] FN_PICK  = 3'd4;

  // status codes of a result
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_NOTQ   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // command broadcast to every cell of the queue row
  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_REMOVE,
    OP_REQUEUE,
    OP_DEC,
    OP_REFILL
  } cell_op_t;

  typedef struct packed {
    logic                phase_a;
    logic                pick;
    logic [ID_BITS-1:0]  task_id;
    logic [ID_BITS-1:0]  new_id;
    cell_op_t            op;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/wrrq_cell.sv */
// ----------------------------------------------------------------------------
// wrrq_cell
// One queue position: holds a task id, weight and slice; shifts forward
// from its right neighbour when a task ahead of or at it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrq_cell #(
  parameter int WEIGHT_BITS = wrrq_pkg::WEIGHT_BITS_D
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wrrq_pkg::cell_ctl_t              ctl,
  input  wire [WEIGHT_BITS-1:0]            new_w,
  input  wire [wrrq_pkg::SLICE_BITS-1:0]   new_slice,
  input  wire                              first,
  input  wire                              left_valid,
  input  wire                              hit_in,
  output logic                             hit_out,
  input  wire                              right_valid,
  input  wire [wrrq_pkg::ID_BITS-1:0]      right_id,
  input  wire [WEIGHT_BITS-1:0]            right_w,
  input  wire [wrrq_pkg::SLICE_BITS-1:0]   right_slice,
  output logic                             valid,
  output logic                             match,
  output logic [wrrq_pkg::ID_BITS-1:0]     id,
  output logic [WEIGHT_BITS-1:0]           weight,
  output logic [wrrq_pkg::SLICE_BITS-1:0]  slice
);

  logic                            valid_r, valid_nxt;
  logic                            match_r;
  logic [wrrq_pkg::ID_BITS-1:0]    id_r, id_nxt;
  logic [WEIGHT_BITS-1:0]          w_r, w_nxt;
  logic [wrrq_pkg::SLICE_BITS-1:0] slice_r, slice_nxt;
  logic                            hit;
  logic                            is_tail;

  assign hit     = hit_in | match_r;
  assign hit_out = hit;
  assign is_tail = valid_r & ~right_valid;

  // select the next content of this position
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    w_nxt     = w_r;
    slice_nxt = slice_r;
    case (ctl.op)
      wrrq_pkg::OP_APPEND: begin
        if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          id_nxt    = ctl.task_id;
          w_nxt     = new_w;
          slice_nxt = new_slice;
        end
      end
      wrrq_pkg::OP_REMOVE: begin
        if (hit) begin
          valid_nxt = right_valid;
          id_nxt    = right_id;
          w_nxt     = right_w;
          slice_nxt = right_slice;
        end
      end
      wrrq_pkg::OP_REQUEUE: begin
        if (is_tail) begin
          id_nxt    = ctl.new_id;
          w_nxt     = new_w;
          slice_nxt = new_slice;
        end else if (hit) begin
          valid_nxt = right_valid;
          id_nxt    = right_id;
          w_nxt     = right_w;
          slice_nxt = right_slice;
        end
      end
      wrrq_pkg::OP_DEC: begin
        if (match_r) slice_nxt = slice_r - 1'b1;
      end
      wrrq_pkg::OP_REFILL: begin
        if (match_r) slice_nxt = new_slice;
      end
      default: begin
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.phase_a) begin
        match_r <= valid_r & (ctl.pick ? first : (id_r == ctl.task_id));
      end
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    w_r     <= w_nxt;
    slice_r <= slice_nxt;
  end

  assign valid  = valid_r;
  assign match  = match_r;
  assign id     = id_r;
  assign weight = w_r;
  assign slice  = slice_r;

endmodule

`default_nettype wire

/* design/weighted_round_robin_run_queue.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_run_queue
// Weighted round-robin run queue kept as a row of shifting queue cells.
// ----------------------------------------------------------------------------
// Channel | Ports          | Contents
// in      | in_t*          | request: operation, task id, weight, policy flag
// out     | out_t*         | result: status, pick, counts, slice
// cfg     | cfg_wr_*       | quantum_ticks register
//
// In the accept cycle of a request every cell compares its task id; in
// S_EXEC the queue row is updated and the result registered.
// The next request is taken once the update cycle has passed. The update
// waits while a previous result is still unaccepted at the output.
// Reset empties the queue at once; the quantum returns to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_round_robin_run_queue #(
  parameter int MAX_TASKS   = wrrq_pkg::MAX_TASKS_D,
  parameter int WEIGHT_BITS = wrrq_pkg::WEIGHT_BITS_D
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // task_id[4:0], task_weight[12:5], task_is_wrr[13]
  input  wire  [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // status[1:0], picked_task[6:2], picked_valid[7],
                                  // resched[8], weight_total[21:9],
                                  // queued_count[27:22], slice_left[43:28]
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = WEIGHT_BITS + CW;
  localparam int PW = WEIGHT_BITS + wrrq_pkg::Q_BITS;
  localparam int SB = wrrq_pkg::SLICE_BITS;
  localparam int IB = wrrq_pkg::ID_BITS;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                    state_r;
  logic [wrrq_pkg::Q_BITS-1:0] q_r;
  logic [2:0]                func_r;
  logic [IB-1:0]             tid_r;
  logic [WEIGHT_BITS-1:0]    w_r;
  logic                      wrr_r;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [AW-1:0]             acc_r, acc_nxt;
  logic                      out_valid_r;
  logic [47:0]               out_data_r;

  logic                      in_acc, advance;
  wrrq_pkg::cell_ctl_t       ctl;
  wrrq_pkg::cell_op_t        op;

  logic [MAX_TASKS-1:0]      c_valid, c_match;
  logic [MAX_TASKS:0]        c_hit;
  logic [IB-1:0]             c_id    [MAX_TASKS];
  logic [WEIGHT_BITS-1:0]    c_w     [MAX_TASKS];
  logic [SB-1:0]             c_slice [MAX_TASKS];

  logic                      found;
  logic [IB-1:0]             found_id;
  logic [WEIGHT_BITS-1:0]    found_w;
  logic [SB-1:0]             found_slice;
  logic                      id_ok;
  logic [WEIGHT_BITS-1:0]    mult_w, load_w;
  logic [PW-1:0]             prod;
  logic [PW+SB:0]            prod_ext;
  logic [SB-1:0]             full_slice;

  logic [1:0]                st;
  logic [IB-1:0]             picked;
  logic                      pvalid, resched;
  logic [SB-1:0]             slice_out;
  logic [12:0]               wtot;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign advance   = (state_r == S_EXEC) & (~out_valid_r | out_tready);

  // gather the fields of the matched cell
  always_comb begin
    found       = 1'b0;
    found_id    = '0;
    found_w     = '0;
    found_slice = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      found       = found | c_match[i];
      found_id    = found_id | (c_id[i] & {IB{c_match[i]}});
      found_w     = found_w | (c_w[i] & {WEIGHT_BITS{c_match[i]}});
      found_slice = found_slice | (c_slice[i] & {SB{c_match[i]}});
    end
  end

  assign id_ok = (32'(tid_r) < 32'(MAX_TASKS));

  // full slice: weight times quantum, saturated
  assign mult_w     = (func_r == wrrq_pkg::FN_ENQ) ? w_r : found_w;
  assign prod       = PW'(mult_w) * PW'(q_r);
  assign prod_ext   = (PW+SB+1)'(prod);
  assign full_slice = (prod_ext > (PW+SB+1)'(65535)) ? {SB{1'b1}} : SB'(prod);
  assign load_w     = mult_w;

  // decide the update and the result
  always_comb begin
    op        = wrrq_pkg::OP_NONE;
    st        = wrrq_pkg::ST_OK;
    picked    = '0;
    pvalid    = 1'b0;
    resched   = 1'b0;
    slice_out = '0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    case (func_r)
      wrrq_pkg::FN_ENQ: begin
        if (!id_ok) begin
          st = wrrq_pkg::ST_NOTQ;
        end else if (found) begin
          st        = wrrq_pkg::ST_DUP;
          slice_out = found_slice;
        end else begin
          op        = wrrq_pkg::OP_APPEND;
          acc_nxt   = acc_r + AW'(w_r);
          cnt_nxt   = cnt_r + 1'b1;
          slice_out = full_slice;
        end
      end
      wrrq_pkg::FN_DEQ: begin
        if (!found) begin
          st = wrrq_pkg::ST_NOTQ;
        end else begin
          op        = wrrq_pkg::OP_REMOVE;
          slice_out = found_slice;
          cnt_nxt   = cnt_r - 1'b1;
          acc_nxt   = acc_r - AW'(found_w);
        end
      end
      wrrq_pkg::FN_TICK: begin
        if (!found) begin
          st = wrrq_pkg::ST_NOTQ;
        end else if (!wrr_r) begin
          slice_out = found_slice;
        end else if (found_slice > SB'(1)) begin
          op        = wrrq_pkg::OP_DEC;
          slice_out = found_slice - 1'b1;
        end else begin
          op        = wrrq_pkg::OP_REQUEUE;
          resched   = 1'b1;
          slice_out = full_slice;
        end
      end
      wrrq_pkg::FN_YIELD: begin
        if (!found) begin
          st = wrrq_pkg::ST_NOTQ;
        end else begin
          op        = wrrq_pkg::OP_REQUEUE;
          slice_out = full_slice;
        end
      end
      wrrq_pkg::FN_PICK: begin
        if (!found) begin
          st = wrrq_pkg::ST_EMPTY;
        end else begin
          op        = wrrq_pkg::OP_REFILL;
          picked    = found_id;
          pvalid    = 1'b1;
          slice_out = full_slice;
        end
      end
      default: begin
      end
    endcase
  end

  assign wtot = (32'(acc_nxt) > 32'd8191) ? 13'h1FFF : 13'(acc_nxt);

  // broadcast command to the row
  always_comb begin
    ctl.phase_a = in_acc;
    ctl.pick    = (in_tuser == wrrq_pkg::FN_PICK);
    ctl.task_id = in_acc ? in_tdata[4:0] : tid_r;
    ctl.new_id  = found_id;
    ctl.op      = advance ? op : wrrq_pkg::OP_NONE;
  end

  // queue row
  assign c_hit[0] = 1'b0;
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic            rv;
    logic [IB-1:0]   rid;
    logic [WEIGHT_BITS-1:0] rw;
    logic [SB-1:0]   rs;
    if (i == MAX_TASKS - 1) begin : g_end
      assign rv  = 1'b0;
      assign rid = '0;
      assign rw  = '0;
      assign rs  = '0;
    end else begin : g_mid
      assign rv  = c_valid[i+1];
      assign rid = c_id[i+1];
      assign rw  = c_w[i+1];
      assign rs  = c_slice[i+1];
    end
    wrrq_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_w       (load_w),
      .new_slice   (full_slice),
      .first       (i == 0),
      .left_valid  ((i == 0) ? 1'b1 : c_valid[(i == 0) ? 0 : i-1]),
      .hit_in      (c_hit[i]),
      .hit_out     (c_hit[i+1]),
      .right_valid (rv),
      .right_id    (rid),
      .right_w     (rw),
      .right_slice (rs),
      .valid       (c_valid[i]),
      .match       (c_match[i]),
      .id          (c_id[i]),
      .weight      (c_w[i]),
      .slice       (c_slice[i])
    );
  end

  // hold state, counters and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_r         <= wrrq_pkg::Q_RESET;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) q_r <= cfg_wr_data;
      if (advance) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {4'b0, slice_out, 6'(cnt_nxt), wtot, resched, pvalid, picked, st};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (advance) begin
            state_r <= S_IDLE;
            cnt_r   <= cnt_nxt;
            acc_r   <= acc_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      tid_r  <= in_tdata[4:0];
      w_r    <= WEIGHT_BITS'(in_tdata[12:5]);
      wrr_r  <= in_tdata[13];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* tb/weighted_round_robin_run_queue_tb.sv */
// ----------------------------------------------------------------------------
// weighted_round_robin_run_queue_tb
// Drives scheduler requests into the run queue under several idling phases
// and quantum settings, predicts every result with a behavioural copy of the
// queue and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_round_robin_run_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  picked_task;
    logic        picked_valid;
    logic        resched;
    logic [12:0] weight_total;
    logic [5:0]  queued_count;
    logic [15:0] slice_left;
  } wrr_result_t;

  // Behavioural run queue: the order is held as a plain list of task ids
  class run_queue_scoreboard;
    logic [4:0]  order[$];
    logic        queued[32];
    logic [7:0]  weight[32];
    logic [15:0] slice[32];
    int unsigned weight_tally;
    logic [7:0]  quantum;
    wrr_result_t pending[$];
    int          errors;
    int          checked;
    int          rescheds;

    function new();
      foreach (queued[i]) begin
        queued[i] = 1'b0;
        weight[i] = '0;
        slice[i]  = '0;
      end
      weight_tally = 0;
      quantum      = wrrq_pkg::Q_RESET;
      errors       = 0;
      checked      = 0;
      rescheds     = 0;
    endfunction

    function logic [15:0] refill(logic [4:0] t);
      int unsigned s;
      s = weight[t] * quantum;
      return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void move_to_tail(logic [4:0] t);
      foreach (order[i]) if (order[i] == t) begin
        order.delete(i);
        break;
      end
      order.push_back(t);
    endfunction

    // note an accepted request and queue the result it must give
    function void note_request(logic [2:0] fn, logic [4:0] t, logic [7:0] w, logic wrr);
      wrr_result_t r;
      r = '0;
      case (fn)
        wrrq_pkg::FN_ENQ: begin
          if (queued[t]) begin
            r.status = wrrq_pkg::ST_DUP;
            r.slice_left = slice[t];
          end else begin
            weight[t] = w;
            slice[t]  = refill(t);
            weight_tally += w;
            queued[t] = 1'b1;
            order.push_back(t);
            r.slice_left = slice[t];
          end
        end
        wrrq_pkg::FN_DEQ: begin
          if (!queued[t]) r.status = wrrq_pkg::ST_NOTQ;
          else begin
            r.slice_left = slice[t];
            foreach (order[i]) if (order[i] == t) begin
              order.delete(i);
              break;
            end
            queued[t] = 1'b0;
            weight_tally -= weight[t];
          end
        end
        wrrq_pkg::FN_TICK: begin
          if (!queued[t]) r.status = wrrq_pkg::ST_NOTQ;
          else begin
            if (wrr) begin
              if (slice[t] > 1) slice[t] = slice[t] - 16'd1;
              else begin
                slice[t] = refill(t);
                move_to_tail(t);
                r.resched = 1'b1;
              end
            end
            r.slice_left = slice[t];
          end
        end
        wrrq_pkg::FN_YIELD: begin
          if (!queued[t]) r.status = wrrq_pkg::ST_NOTQ;
          else begin
            slice[t] = refill(t);
            move_to_tail(t);
            r.slice_left = slice[t];
          end
        end
        wrrq_pkg::FN_PICK: begin
          if (order.size() == 0) r.status = wrrq_pkg::ST_EMPTY;
          else begin
            r.picked_task  = order[0];
            r.picked_valid = 1'b1;
            slice[order[0]] = refill(order[0]);
            r.slice_left = slice[order[0]];
          end
        end
        default: ;
      endcase
      r.weight_total = (weight_tally > 8191) ? 13'h1FFF : weight_tally[12:0];
      r.queued_count = 6'(order.size());
      pending.push_back(r);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [47:0] d);
      wrr_result_t e, a;
      a.status       = d[1:0];
      a.picked_task  = d[6:2];
      a.picked_valid = d[7];
      a.resched      = d[8];
      a.weight_total = d[21:9];
      a.queued_count = d[27:22];
      a.slice_left   = d[43:28];
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.resched) rescheds++;
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status); errors++;
      end
      if (a.picked_task !== e.picked_task) begin
        $error("picked_task: expected %0d, got %0d", e.picked_task, a.picked_task); errors++;
      end
      if (a.picked_valid !== e.picked_valid) begin
        $error("picked_valid: expected %0d, got %0d", e.picked_valid, a.picked_valid);
        errors++;
      end
      if (a.resched !== e.resched) begin
        $error("resched: expected %0d, got %0d", e.resched, a.resched); errors++;
      end
      if (a.weight_total !== e.weight_total) begin
        $error("weight_total: expected %0d, got %0d", e.weight_total, a.weight_total);
        errors++;
      end
      if (a.queued_count !== e.queued_count) begin
        $error("queued_count: expected %0d, got %0d", e.queued_count, a.queued_count);
        errors++;
      end
      if (a.slice_left !== e.slice_left) begin
        $error("slice_left: expected %0d, got %0d", e.slice_left, a.slice_left); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [15:0] in_tdata = '0;    // task_id[4:0], task_weight[12:5], task_is_wrr[13]
  logic [2:0]  in_tuser = '0;    // func[2:0]
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [47:0] out_tdata;        // status, picked_task, picked_valid, resched,
                                 // weight_total, queued_count, slice_left
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_off_left  = 0;
  bit hold_off_go    = 1'b0;
  bit hold_off_used  = 1'b0;
  int quiet_cycles   = 0;
  int requests_sent  = 0;
  bit sim_done       = 1'b0;

  run_queue_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  weighted_round_robin_run_queue i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Receiver: random stall, or a long hold-off when one is armed
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_off_go && !hold_off_used) begin
      hold_off_used <= 1'b1;
      hold_off_left <= 200;
      out_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || sim_done)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] fn, logic [4:0] t, logic [7:0] w, logic wrr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, wrr, w, t};
    do @(posedge clk); while (!in_tready);
    sb.note_request(fn, t, w, wrr);
    requests_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_quantum(logic [7:0] q);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.quantum = q;
  endtask

  // Mixed traffic, heaviest in ticks, over a subset of ids so the queue stays busy
  task automatic random_requests(int n, int id_span);
    logic [2:0] fn;
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 25) fn = wrrq_pkg::FN_ENQ;
      else if (r < 40) fn = wrrq_pkg::FN_DEQ;
      else if (r < 75) fn = wrrq_pkg::FN_TICK;
      else if (r < 85) fn = wrrq_pkg::FN_YIELD;
      else if (r < 97) fn = wrrq_pkg::FN_PICK;
      else fn = 3'($urandom_range(5, 7));
      send_request(fn, 5'($urandom_range(id_span)), ($urandom_range(9) == 0) ?
                   8'($urandom_range(1, 255)) : 8'($urandom_range(1, 3)),
                   ($urandom_range(9) != 0));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pick, extremes, duplicates, missing tasks, expiry
    send_request(wrrq_pkg::FN_PICK, 5'd0, 8'd1, 1'b0);
    send_request(wrrq_pkg::FN_DEQ, 5'd31, 8'd1, 1'b0);
    send_request(wrrq_pkg::FN_TICK, 5'd3, 8'd1, 1'b1);
    send_request(wrrq_pkg::FN_YIELD, 5'd3, 8'd1, 1'b1);
    send_request(wrrq_pkg::FN_ENQ, 5'd0, 8'd255, 1'b0);
    send_request(wrrq_pkg::FN_ENQ, 5'd31, 8'd1, 1'b1);
    send_request(wrrq_pkg::FN_ENQ, 5'd31, 8'd7, 1'b1);
    send_request(wrrq_pkg::FN_ENQ, 5'd10, 8'h55, 1'b0);
    send_request(wrrq_pkg::FN_TICK, 5'd0, 8'd0, 1'b0);
    send_request(wrrq_pkg::FN_YIELD, 5'd0, 8'd0, 1'b0);
    send_request(wrrq_pkg::FN_PICK, 5'd0, 8'd0, 1'b0);
    send_request(wrrq_pkg::FN_DEQ, 5'd10, 8'hAA, 1'b0);
    send_request(3'd5, 5'd1, 8'd1, 1'b1);
    send_request(3'd7, 5'd2, 8'd1, 1'b0);
    set_quantum(8'd1);
    send_request(wrrq_pkg::FN_YIELD, 5'd31, 8'd0, 1'b0);
    send_request(wrrq_pkg::FN_TICK, 5'd31, 8'd0, 1'b1);
    send_request(wrrq_pkg::FN_TICK, 5'd31, 8'd0, 1'b1);
    send_request(wrrq_pkg::FN_DEQ, 5'd0, 8'd0, 1'b0);
    send_request(wrrq_pkg::FN_TICK, 5'd31, 8'd0, 1'b1);
    send_request(wrrq_pkg::FN_DEQ, 5'd31, 8'd0, 1'b0);
    send_request(wrrq_pkg::FN_PICK, 5'd0, 8'd0, 1'b0);

    // full queue, then long receiver hold-off while the sender keeps going
    set_quantum(8'd255);
    for (int i = 0; i < 32; i++) send_request(wrrq_pkg::FN_ENQ, 5'(i), 8'd255, 1'b1);
    send_request(wrrq_pkg::FN_PICK, 5'd0, 8'd0, 1'b0);
    hold_off_go = 1'b1;
    random_requests(40, 31);
    drain();
    for (int i = 0; i < 32; i++) send_request(wrrq_pkg::FN_DEQ, 5'(i), 8'd0, 1'b0);

    // random phases over quantum settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      set_quantum((ph == 0) ? 8'd1 : (ph == 7) ? 8'd255 : 8'($urandom_range(1, 4)));
      random_requests(200, (ph % 2) ? 31 : 7);
    end

    drain();
    repeat (20) @(posedge clk);
    sim_done = 1'b1;
    $display("covered %0d requests, %0d results checked, %0d reschedules seen",
             requests_sent, sb.checked, sb.rescheds);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
design/wrrq_pkg.sv
design/wrrq_cell.sv
design/weighted_round_robin_run_queue.sv
tb/weighted_round_robin_run_queue_tb.sv
